// ===== rtl/lprp_pkg.sv =====
// lprp_pkg: shared types, codes and reset constants of the link parameter request policy
package lprp_pkg;

    // event operation codes
    typedef enum logic [2:0] {
        OP_CONNECT    = 3'd0,
        OP_DISCONNECT = 3'd1,
        OP_GRANT      = 3'd2,
        OP_FOREGROUND = 3'd3,
        OP_STEP       = 3'd4,
        OP_DIVERGENCE = 3'd5
    } t_op;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SESSION_PARAMS  = 2'd0,
        CFG_IDLE_PARAMS     = 2'd1,
        CFG_GRACE_MS        = 2'd2,
        CFG_IDLE_HOLDOFF_MS = 2'd3
    } t_cfg_idx;

    // link profile codes
    localparam logic PROFILE_SESSION = 1'b0;
    localparam logic PROFILE_IDLE    = 1'b1;

    localparam int unsigned CFG_DATA_W = 64;

    // configuration reset values
    localparam logic [63:0] SESSION_PARAMS_RST = 64'h0190_0000_0018_000C;
    localparam logic [63:0] IDLE_PARAMS_RST    = 64'h0258_0004_0064_0050;
    localparam logic [31:0] GRACE_MS_RST       = 32'd5000;
    localparam logic [31:0] IDLE_HOLDOFF_RST   = 32'd30000;

    // input event
    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] now_ms;
        logic        foreground_active;
        logic [15:0] grant_interval;
        logic [15:0] grant_latency;
        logic [15:0] grant_timeout;
    } t_event;

    // result of one event
    typedef struct packed {
        logic        request_valid;
        logic        request_profile;
        logic [15:0] request_interval_min;
        logic [15:0] request_interval_max;
        logic [15:0] request_latency;
        logic [15:0] request_timeout;
        logic        divergence_due;
    } t_result;

    // configuration registers
    typedef struct packed {
        logic [63:0] session_params;
        logic [63:0] idle_params;
        logic [31:0] grace_ms;
        logic [31:0] idle_holdoff_ms;
    } t_cfg;

    // policy state
    typedef struct packed {
        logic        in_flight;
        logic [31:0] request_time;
        logic        desired_profile;
        logic        requested_profile;
        logic        current_profile;
        logic [15:0] held_interval_min;
        logic [15:0] held_interval_max;
        logic [15:0] held_latency;
        logic [15:0] held_timeout;
        logic        grant_matched;
        logic        divergence_reported;
        logic [31:0] absent_since;
    } t_state;

    localparam t_state STATE_RST = '{
        in_flight:           1'b0,
        request_time:        32'd0,
        desired_profile:     PROFILE_IDLE,
        requested_profile:   PROFILE_IDLE,
        current_profile:     PROFILE_IDLE,
        held_interval_min:   16'd0,
        held_interval_max:   16'd0,
        held_latency:        16'd0,
        held_timeout:        16'd0,
        grant_matched:       1'b0,
        divergence_reported: 1'b0,
        absent_since:        32'd0
    };

endpackage

// ===== rtl/lprp_stream_if.sv =====
// lprp_stream_if: valid/ready channel carrying one request payload
interface lprp_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/lprp_decide.sv =====
// lprp_decide: next state and result of the policy for one event
module lprp_decide import lprp_pkg::*; (
    input  t_event  i_event,
    input  t_state  i_state,
    input  t_cfg    i_cfg,
    output t_state  o_state,
    output t_result o_result
);

    logic [31:0] since_req;
    logic        past_grace;
    logic        want;
    logic [63:0] prof;
    logic        issue;
    logic [31:0] absent_base;
    logic [31:0] since_absent;
    logic        grant_ok;

    // shared timing and matching terms
    always_comb begin
        since_req    = i_event.now_ms - i_state.request_time;
        past_grace   = since_req > i_cfg.grace_ms;
        want         = (t_op'(i_event.operation) == OP_CONNECT) ? PROFILE_SESSION
                                                                 : i_state.desired_profile;
        prof         = (want == PROFILE_IDLE) ? i_cfg.idle_params : i_cfg.session_params;
        issue        = (!i_state.in_flight || past_grace) && (want != i_state.current_profile);
        absent_base  = (i_state.absent_since == 32'd0) ? i_event.now_ms : i_state.absent_since;
        since_absent = i_event.now_ms - absent_base;
        grant_ok     = (i_state.held_interval_min == 16'd0) ||
                       ((i_event.grant_interval >= i_state.held_interval_min) &&
                        (i_event.grant_interval <= i_state.held_interval_max) &&
                        (i_event.grant_latency == i_state.held_latency) &&
                        (i_event.grant_timeout == i_state.held_timeout));
    end

    // per-operation update
    always_comb begin
        o_state  = i_state;
        o_result = '0;
        unique case (t_op'(i_event.operation)) inside
            OP_CONNECT, OP_STEP: begin
                if (t_op'(i_event.operation) == OP_CONNECT) begin
                    o_state.absent_since    = i_event.now_ms;
                    o_state.desired_profile = PROFILE_SESSION;
                end
                // an expired request no longer blocks a retry
                if (i_state.in_flight && past_grace) begin
                    o_state.in_flight = 1'b0;
                end
                if (issue) begin
                    o_state.requested_profile   = want;
                    o_state.in_flight           = 1'b1;
                    o_state.held_interval_min   = prof[15:0];
                    o_state.held_interval_max   = prof[31:16];
                    o_state.held_latency        = prof[47:32];
                    o_state.held_timeout        = prof[63:48];
                    o_state.request_time        = i_event.now_ms;
                    o_state.grant_matched       = 1'b0;
                    o_state.divergence_reported = 1'b0;
                    o_result.request_valid        = 1'b1;
                    o_result.request_profile      = want;
                    o_result.request_interval_min = prof[15:0];
                    o_result.request_interval_max = prof[31:16];
                    o_result.request_latency      = prof[47:32];
                    o_result.request_timeout      = prof[63:48];
                end
            end
            OP_DISCONNECT: begin
                // latency and timeout are kept across a disconnect
                o_state.held_interval_min = 16'd0;
                o_state.held_interval_max = 16'd0;
                o_state.current_profile   = PROFILE_IDLE;
                o_state.desired_profile   = PROFILE_IDLE;
                o_state.requested_profile = PROFILE_IDLE;
                o_state.in_flight         = 1'b0;
            end
            OP_GRANT: begin
                o_state.grant_matched = grant_ok;
                if (grant_ok) begin
                    o_state.current_profile = i_state.requested_profile;
                    o_state.in_flight       = 1'b0;
                end
            end
            OP_FOREGROUND: begin
                if (i_event.foreground_active) begin
                    o_state.absent_since    = 32'd0;
                    o_state.desired_profile = PROFILE_SESSION;
                end else begin
                    o_state.absent_since    = absent_base;
                    o_state.desired_profile = (since_absent >= i_cfg.idle_holdoff_ms)
                                              ? PROFILE_IDLE : PROFILE_SESSION;
                end
            end
            OP_DIVERGENCE: begin
                // zero request time or nothing requested suppresses the report
                if (!i_state.grant_matched && !i_state.divergence_reported &&
                    (i_state.held_interval_min != 16'd0) &&
                    (i_state.request_time != 32'd0) && past_grace) begin
                    o_state.divergence_reported = 1'b1;
                    o_result.divergence_due     = 1'b1;
                end
            end
            default: begin
                // unused codes leave state alone and give an all-zero result
            end
        endcase
    end

endmodule

// ===== rtl/link_param_request_policy.sv =====
// link_param_request_policy: top level of the connection parameter request policy
//
//  channel    dir  payload   handshake
//  i_event    in   t_event   valid/ready, one request per event
//  o_result   out  t_result  valid/ready, exactly one result per event
//  i_cfg_*    in   64-bit    write enable, no back-pressure
//
// One event per cycle sustained while o_result is not stalled; an accepted event
// waits in the input register, then the policy logic and state update go in a
// single step into the result register.
// Reset (synchronous, active low) loads the register defaults and the idle state.
// A stalled result holds the input register; a new event is taken while the
// result leaves in the same cycle.
module link_param_request_policy import lprp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lprp_stream_if.sink           i_event,
    lprp_stream_if.source         o_result,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic    r_in_valid;
    t_event  r_in;
    logic    r_out_valid;
    t_result r_out;
    t_state  r_state;
    t_cfg    r_cfg;

    t_state  n_state;
    t_result n_out;
    logic    out_free;
    logic    advance;

    // handshake control
    assign out_free      = !r_out_valid || o_result.ready;
    assign advance       = r_in_valid && out_free;
    assign i_event.ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_event.ready) begin
            r_in_valid <= i_event.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_event.valid && i_event.ready) begin
            r_in <= i_event.data;
        end
    end

    // policy logic
    lprp_decide u_decide (
        .i_event  (r_in),
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RST;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.session_params  <= SESSION_PARAMS_RST;
            r_cfg.idle_params     <= IDLE_PARAMS_RST;
            r_cfg.grace_ms        <= GRACE_MS_RST;
            r_cfg.idle_holdoff_ms <= IDLE_HOLDOFF_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SESSION_PARAMS:  r_cfg.session_params  <= i_cfg_data;
                CFG_IDLE_PARAMS:     r_cfg.idle_params     <= i_cfg_data;
                CFG_GRACE_MS:        r_cfg.grace_ms        <= i_cfg_data[31:0];
                CFG_IDLE_HOLDOFF_MS: r_cfg.idle_holdoff_ms <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    // a pending request result leaves a request in flight behind it
    a_req_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.request_valid |-> r_state.in_flight)
        else $error("request issued without in-flight state");

    // the issued minimum interval and timeout are what the state holds for matching
    a_req_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.request_valid |->
            (r_out.request_interval_min == r_state.held_interval_min) &&
            (r_out.request_timeout == r_state.held_timeout))
        else $error("issued request differs from held values");

    // one event never both requests and reports divergence
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.request_valid && r_out.divergence_due))
        else $error("request and divergence in one result");

    // state moves only with an event passing to the result register
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("state changed without an event");

endmodule
